// ===== sv/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants of the epsilon-NFA subset construction unit.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

   localparam int NFA_STATES = 16;
   localparam int ALPHABET   = 26;
   localparam int DFA_STATES = 64;

   localparam int SET_W      = 16;
   localparam int NFA_W      = $clog2(NFA_STATES);
   localparam int SYM_W      = 5;
   localparam int DFA_AW     = $clog2(DFA_STATES);
   localparam int DFA_CW     = DFA_AW + 1;
   localparam int MOVE_DEPTH = NFA_STATES * ALPHABET;
   localparam int MOVE_AW    = $clog2(MOVE_DEPTH);
   localparam int BUF_AW     = $clog2(ALPHABET);
   localparam int BUF_CW     = $clog2(ALPHABET + 1);

   typedef enum logic [1:0] {
      OP_LOAD_SYM = 2'd0,
      OP_LOAD_EPS = 2'd1,
      OP_START    = 2'd2,
      OP_EXPAND   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_SETUP,
      ST_MOVE,
      ST_MOVE_LAST,
      ST_CLOSE,
      ST_SEARCH,
      ST_NEXT_SYM,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [3:0]  nfa_state;
      logic [4:0]  symbol_index;
      logic [15:0] target_mask;
   } req_type;

   typedef struct packed {
      logic        has_transition;
      logic [5:0]  from_dfa;
      logic [4:0]  letter;
      logic [5:0]  to_dfa;
      logic [15:0] to_set;
      logic        is_new;
      logic        overflow;
      logic        finished;
      logic        last;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/epsilon_nfa_subset_construction_unit.sv =====
// ----------------------------------------------------------------------------
// epsilon_nfa_subset_construction_unit
// Subset construction of a DFA from an epsilon-NFA under a small sequencer.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_valid / req_stall | esc_pkg::req_type
//   rsp     | out | rsp_valid / rsp_stall | esc_pkg::rsp_type
//
// Load transactions complete in idle; start runs closure steps to a fixpoint.
// Expand: per letter, move table reads over all NFA states, closure steps to
// a fixpoint, and search reads of the DFA set RAM until a match or all known
// sets are read; then one result per cycle while rsp is not stalled.
// After reset a clearing pass zeroes the move table; req stalls.
// Start and expand stall req until closure ends or the last result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module epsilon_nfa_subset_construction_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire esc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output esc_pkg::rsp_type      rsp_data
);
   import esc_pkg::*;

   state_type state_ff, state_in;

   logic [MOVE_AW-1:0] clr_ff, clr_in;
   logic [DFA_CW-1:0]  count_ff, count_in;
   logic [DFA_CW-1:0]  ptr_ff, ptr_in;
   logic [DFA_AW-1:0]  from_ff, from_in;
   logic [SET_W-1:0]   cur_ff, cur_in;
   logic [SET_W-1:0]   acc_ff, acc_in;
   logic [SET_W-1:0]   set_ff, set_in;
   logic [SYM_W-1:0]   sym_ff, sym_in;
   logic [MOVE_AW-1:0] base_ff, base_in;
   logic [NFA_W-1:0]   idx_ff, idx_in;
   logic               mpend_ff, mpend_in;
   logic [DFA_CW-1:0]  j_ff, j_in;
   logic [DFA_AW-1:0]  jd_ff, jd_in;
   logic               spend_ff, spend_in;
   logic               start_ff, start_in;
   logic [BUF_CW-1:0]  n_ff, n_in;
   logic [BUF_CW-1:0]  eidx_ff, eidx_in;
   logic               fin_ff, fin_in;
   rsp_type            buf_ff [ALPHABET];
   logic               buf_we;
   rsp_type            buf_wd;

   logic               mv_we;
   logic [MOVE_AW-1:0] mv_wa, mv_ra;
   logic [SET_W-1:0]   mv_wd, mv_rd;
   logic               df_we;
   logic [DFA_AW-1:0]  df_wa, df_ra;
   logic [SET_W-1:0]   df_wd, df_rd;
   logic               clo_we;
   logic [SET_W-1:0]   clo_step;

   logic req_fire, rsp_fire, emit_last, match, srch_done, stable;

   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign emit_last = (eidx_ff == n_ff - BUF_CW'(1));
   assign match     = spend_ff && (df_rd == set_ff);
   assign srch_done = (j_ff == count_ff);
   assign stable    = (clo_step == set_ff);

   esc_ram #(.WIDTH(SET_W), .DEPTH(MOVE_DEPTH)) u_move_ram (
      .clock   (clock),
      .wr_en   (mv_we),
      .wr_addr (mv_wa),
      .wr_data (mv_wd),
      .rd_addr (mv_ra),
      .rd_data (mv_rd)
   );

   esc_ram #(.WIDTH(SET_W), .DEPTH(DFA_STATES)) u_dfa_ram (
      .clock   (clock),
      .wr_en   (df_we),
      .wr_addr (df_wa),
      .wr_data (df_wd),
      .rd_addr (df_ra),
      .rd_data (df_rd)
   );

   esc_closure_unit u_closure (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (clo_we),
      .wr_idx   (req_data.nfa_state),
      .wr_mask  (req_data.target_mask),
      .set_in   (set_ff),
      .step_out (clo_step)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == MOVE_AW'(MOVE_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (op_type'(req_data.operation))
                  OP_START:  state_in = ST_CLOSE;
                  OP_EXPAND: state_in = (ptr_ff >= count_ff) ? ST_EMIT : ST_FETCH;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_FETCH:     state_in = ST_SETUP;
         ST_SETUP:     state_in = ST_MOVE;
         ST_MOVE: begin
            if (idx_ff == NFA_W'(NFA_STATES - 1)) state_in = ST_MOVE_LAST;
         end
         ST_MOVE_LAST: state_in = ST_CLOSE;
         ST_CLOSE: begin
            if (stable) begin
               if (start_ff)           state_in = ST_IDLE;
               else if (set_ff == '0)  state_in = ST_NEXT_SYM;
               else                    state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (match || srch_done) state_in = ST_NEXT_SYM;
         end
         ST_NEXT_SYM: begin
            state_in = (sym_ff == SYM_W'(ALPHABET - 1)) ? ST_EMIT : ST_MOVE;
         end
         ST_EMIT: begin
            if (rsp_fire && emit_last) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // port and memory controls
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT);
      mv_we     = 1'b0;
      mv_wa     = clr_ff;
      mv_wd     = '0;
      mv_ra     = base_ff;
      df_we     = 1'b0;
      df_wa     = count_ff[DFA_AW-1:0];
      df_wd     = set_ff;
      df_ra     = j_ff[DFA_AW-1:0];
      clo_we    = 1'b0;
      case (state_ff)
         ST_CLEAR: mv_we = 1'b1;
         ST_IDLE: begin
            df_ra = ptr_ff[DFA_AW-1:0];
            if (req_fire && op_type'(req_data.operation) == OP_LOAD_SYM &&
                req_data.symbol_index < SYM_W'(ALPHABET)) begin
               mv_we = 1'b1;
               mv_wa = MOVE_AW'(int'(req_data.nfa_state) * ALPHABET +
                                int'(req_data.symbol_index));
               mv_wd = req_data.target_mask;
            end
            if (req_fire && op_type'(req_data.operation) == OP_LOAD_EPS) begin
               clo_we = 1'b1;
            end
         end
         // hold the read address so the set is still on the port in setup
         ST_FETCH: df_ra = from_ff;
         ST_CLOSE: begin
            if (stable && start_ff) begin
               df_we = 1'b1;
               df_wa = '0;
            end
         end
         ST_SEARCH: begin
            if (!match && srch_done && count_ff < DFA_CW'(DFA_STATES)) df_we = 1'b1;
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      clr_in   = clr_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      from_in  = from_ff;
      cur_in   = cur_ff;
      acc_in   = acc_ff;
      set_in   = set_ff;
      sym_in   = sym_ff;
      base_in  = base_ff;
      idx_in   = idx_ff;
      mpend_in = 1'b0;
      j_in     = j_ff;
      jd_in    = jd_ff;
      spend_in = 1'b0;
      start_in = start_ff;
      n_in     = n_ff;
      eidx_in  = eidx_ff;
      fin_in   = fin_ff;
      buf_we   = 1'b0;
      buf_wd   = '0;
      case (state_ff)
         ST_CLEAR: clr_in = clr_ff + MOVE_AW'(1);
         ST_IDLE: begin
            eidx_in = '0;
            if (req_fire) begin
               case (op_type'(req_data.operation))
                  OP_START: begin
                     start_in = 1'b1;
                     set_in   = SET_W'(1) << req_data.nfa_state;
                  end
                  OP_EXPAND: begin
                     start_in = 1'b0;
                     if (ptr_ff >= count_ff) begin
                        buf_we = 1'b1;
                        n_in   = BUF_CW'(1);
                        fin_in = 1'b1;
                     end else begin
                        from_in = ptr_ff[DFA_AW-1:0];
                        ptr_in  = ptr_ff + DFA_CW'(1);
                        n_in    = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SETUP: begin
            cur_in  = df_rd;
            sym_in  = '0;
            base_in = '0;
            idx_in  = '0;
            acc_in  = '0;
         end
         ST_MOVE, ST_MOVE_LAST: begin
            if (mpend_ff) acc_in = acc_ff | mv_rd;
            if (state_ff == ST_MOVE) begin
               mpend_in = cur_ff[idx_ff];
               idx_in   = idx_ff + NFA_W'(1);
               base_in  = base_ff + MOVE_AW'(ALPHABET);
            end else begin
               set_in = mpend_ff ? (acc_ff | mv_rd) : acc_ff;
               j_in   = '0;
            end
         end
         ST_CLOSE: begin
            set_in = clo_step;
            j_in   = '0;
            if (stable && start_ff) begin
               count_in = DFA_CW'(1);
               ptr_in   = '0;
            end
         end
         ST_SEARCH: begin
            buf_wd.has_transition = 1'b1;
            buf_wd.from_dfa       = 6'(from_ff);
            buf_wd.letter         = sym_ff;
            buf_wd.to_set         = set_ff;
            if (match) begin
               buf_we        = 1'b1;
               buf_wd.to_dfa = 6'(jd_ff);
               n_in          = n_ff + BUF_CW'(1);
            end else if (srch_done) begin
               buf_we = 1'b1;
               n_in   = n_ff + BUF_CW'(1);
               if (count_ff < DFA_CW'(DFA_STATES)) begin
                  buf_wd.to_dfa = 6'(count_ff[DFA_AW-1:0]);
                  buf_wd.is_new = 1'b1;
                  count_in      = count_ff + DFA_CW'(1);
               end else begin
                  buf_wd.overflow = 1'b1;
               end
            end else begin
               spend_in = 1'b1;
               jd_in    = j_ff[DFA_AW-1:0];
               j_in     = j_ff + DFA_CW'(1);
            end
         end
         ST_NEXT_SYM: begin
            sym_in  = sym_ff + SYM_W'(1);
            base_in = MOVE_AW'(sym_ff) + MOVE_AW'(1);
            idx_in  = '0;
            acc_in  = '0;
            if (sym_ff == SYM_W'(ALPHABET - 1)) begin
               fin_in = (ptr_ff >= count_ff);
               if (n_ff == '0) begin
                  buf_we          = 1'b1;
                  buf_wd.from_dfa = 6'(from_ff);
                  n_in            = BUF_CW'(1);
               end
            end
         end
         ST_EMIT: begin
            if (rsp_fire) eidx_in = eidx_ff + BUF_CW'(1);
            // empty the buffer so the next transaction writes from slot zero
            if (rsp_fire && emit_last) n_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         count_ff <= '0;
         ptr_ff   <= '0;
         mpend_ff <= 1'b0;
         spend_ff <= 1'b0;
         start_ff <= 1'b0;
         n_ff     <= '0;
         eidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         mpend_ff <= mpend_in;
         spend_ff <= spend_in;
         start_ff <= start_in;
         n_ff     <= n_in;
         eidx_ff  <= eidx_in;
      end
   end

   always_ff @(posedge clock) begin
      from_ff <= from_in;
      cur_ff  <= cur_in;
      acc_ff  <= acc_in;
      set_ff  <= set_in;
      sym_ff  <= sym_in;
      base_ff <= base_in;
      idx_ff  <= idx_in;
      j_ff    <= j_in;
      jd_ff   <= jd_in;
      fin_ff  <= fin_in;
      if (buf_we) buf_ff[n_ff[BUF_AW-1:0]] <= buf_wd;
   end

   always_comb begin
      rsp_data          = buf_ff[eidx_ff[BUF_AW-1:0]];
      rsp_data.finished = fin_ff;
      rsp_data.last     = emit_last;
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DFA_CW'(DFA_STATES))
      else $error("DFA state count beyond store depth");

   a_ptr_le_count: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= count_ff)
      else $error("expand pointer ahead of DFA state count");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (eidx_ff < n_ff))
      else $error("result index beyond buffered results");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_data.last) |=> (!rsp_valid && !req_stall))
      else $error("results continue after last transaction");
`endif

endmodule

`default_nettype wire

// ===== sv/esc_ram.sv =====
// ----------------------------------------------------------------------------
// esc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/esc_closure_unit.sv =====
// ----------------------------------------------------------------------------
// esc_closure_unit
// Epsilon rows and one closure step: set OR the epsilon rows of its members.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_closure_unit (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     wr_en,
   input  wire logic [esc_pkg::NFA_W-1:0] wr_idx,
   input  wire logic [esc_pkg::SET_W-1:0] wr_mask,
   input  wire logic [esc_pkg::SET_W-1:0] set_in,
   output logic      [esc_pkg::SET_W-1:0] step_out
);
   import esc_pkg::*;

   logic [SET_W-1:0] eps_ff [NFA_STATES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NFA_STATES; i++) begin
            eps_ff[i] <= '0;
         end
      end else if (wr_en) begin
         eps_ff[wr_idx] <= wr_mask;
      end
   end

   always_comb begin
      step_out = set_in;
      for (int i = 0; i < NFA_STATES; i++) begin
         if (set_in[i]) begin
            step_out = step_out | eps_ff[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== test/esc_checker.sv =====
// ----------------------------------------------------------------------------
// esc_checker
// Watches both channels of the subset construction unit, predicts the result
// transactions of every accepted request and compares them field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire esc_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire esc_pkg::rsp_type rsp_data,
   output int                    fail_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import esc_pkg::*;

   localparam int EXP_DEPTH = 64;

   logic [SET_W-1:0] move_rows [NFA_STATES*ALPHABET];
   logic [SET_W-1:0] eps_rows [NFA_STATES];
   logic [SET_W-1:0] known_sets [DFA_STATES];
   int               known_count;
   int               next_expand;
   rsp_type          expected_rsps [EXP_DEPTH];
   int               exp_wr;
   int               exp_rd;

   assign pending_count = exp_wr - exp_rd;

   function automatic logic [SET_W-1:0] close_over_eps(logic [SET_W-1:0] s);
      logic [SET_W-1:0] grown;
      forever begin
         grown = s;
         for (int i = 0; i < NFA_STATES; i++)
            if (s[i]) grown |= eps_rows[i];
         if (grown == s) return s;
         s = grown;
      end
   endfunction

   task automatic add_expected(rsp_type t);
      expected_rsps[exp_wr % EXP_DEPTH] = t;
      exp_wr++;
   endtask

   task automatic predict_transaction(req_type r);
      rsp_type          t;
      logic [SET_W-1:0] mv, c, cur;
      int               from, hit, n;
      op_type           op;
      op = op_type'(r.operation);
      case (op)
         OP_LOAD_SYM: begin
            if (r.symbol_index < ALPHABET)
               move_rows[r.nfa_state*ALPHABET + r.symbol_index] = r.target_mask;
         end
         OP_LOAD_EPS: eps_rows[r.nfa_state] = r.target_mask;
         OP_START: begin
            known_sets[0] = close_over_eps(SET_W'(1) << r.nfa_state);
            known_count = 1;
            next_expand = 0;
         end
         OP_EXPAND: begin
            if (next_expand >= known_count) begin
               t = '0;
               t.finished = 1'b1;
               t.last = 1'b1;
               add_expected(t);
            end else begin
               from = next_expand;
               cur = known_sets[from];
               next_expand++;
               n = 0;
               for (int s = 0; s < ALPHABET; s++) begin
                  mv = '0;
                  for (int i = 0; i < NFA_STATES; i++)
                     if (cur[i]) mv |= move_rows[i*ALPHABET + s];
                  c = close_over_eps(mv);
                  if (c != '0) begin
                     hit = -1;
                     for (int j = 0; j < known_count; j++)
                        if (hit < 0 && known_sets[j] == c) hit = j;
                     t = '0;
                     t.has_transition = 1'b1;
                     t.from_dfa = 6'(from);
                     t.letter = 5'(s);
                     t.to_set = c;
                     if (hit >= 0) t.to_dfa = 6'(hit);
                     else if (known_count < DFA_STATES) begin
                        known_sets[known_count] = c;
                        t.to_dfa = 6'(known_count);
                        t.is_new = 1'b1;
                        known_count++;
                     end else t.overflow = 1'b1;
                     add_expected(t);
                     n++;
                  end
               end
               if (n == 0) begin
                  t = '0;
                  t.from_dfa = 6'(from);
                  add_expected(t);
                  n = 1;
               end
               for (int k = exp_wr - n; k < exp_wr; k++) begin
                  expected_rsps[k % EXP_DEPTH].finished = next_expand >= known_count;
                  expected_rsps[k % EXP_DEPTH].last = k == exp_wr - 1;
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (move_rows[i]) move_rows[i] <= '0;
         foreach (eps_rows[i]) eps_rows[i] <= '0;
         known_count <= 0;
         next_expand <= 0;
         fail_count <= 0;
         exp_wr = 0;
         exp_rd = 0;
      end else begin
         if (req_valid && !req_stall) predict_transaction(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (exp_wr == exp_rd) begin
               if (fail_count < 10) $display("unexpected result %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps[exp_rd % EXP_DEPTH];
               exp_rd++;
               if (want !== rsp_data) begin
                  if (fail_count < 10) $display("mismatch exp %p got %p", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

`default_nettype wire

// ===== test/tb_epsilon_nfa_subset_construction_unit.sv =====
// ----------------------------------------------------------------------------
// tb_epsilon_nfa_subset_construction_unit
// Drives load, start and expand transactions into the subset construction
// unit under random idling on both sides and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_epsilon_nfa_subset_construction_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import esc_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count, pending_count;
   int      send_idle_pct, recv_idle_pct;
   int      cycle_count = 0;

   always #1 clock = ~clock;

   epsilon_nfa_subset_construction_unit i_dut (.*);

   esc_checker i_checker (.*);

   always @(posedge clock) begin
      rsp_stall <= $urandom_range(99) < recv_idle_pct;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // valid stays high after acceptance; an idle cycle of the next send or an explicit drop clears it
   task automatic send(op_type op, int st, int sym, logic [15:0] mask);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data <= '{op, st[3:0], sym[4:0], mask};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // build a random NFA with sparse rows, then walk it with expands
   task automatic run_construction(int density);
      int loads;
      loads = $urandom_range(20, 5);
      for (int i = 0; i < loads; i++)
         send(OP_LOAD_SYM, $urandom_range(15), $urandom_range(25),
              (16'(1) << $urandom_range(15)) | ($urandom_range(99) < density ? 16'($urandom) : 16'h0));
      if ($urandom_range(3) == 0)
         send(OP_LOAD_EPS, $urandom_range(15), 0, 16'(1) << $urandom_range(15));
      send(OP_START, $urandom_range(15), 0, 16'($urandom));
      for (int i = $urandom_range(12, 3); i > 0; i--) send(OP_EXPAND, 0, 0, 16'($urandom));
   endtask

   initial begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // directed
      send(OP_EXPAND, 0, 0, '0);
      send(OP_START, 0, 0, '0);
      send(OP_EXPAND, 0, 0, '0);
      send(OP_LOAD_SYM, 0, 0, 16'hFFFF);
      send(OP_LOAD_SYM, 15, 25, 16'h8001);
      send(OP_LOAD_SYM, 3, 31, 16'hFFFF);
      send(OP_LOAD_SYM, 0, 1, 16'h0001);
      send(OP_LOAD_EPS, 15, 0, 16'h0002);
      send(OP_LOAD_EPS, 1, 0, 16'h0000);
      send(OP_START, 15, 0, '0);
      send(OP_EXPAND, 0, 0, '0);
      send(OP_EXPAND, 0, 0, '0);
      send(OP_EXPAND, 0, 0, '0);
      send(OP_START, 3, 0, '0);
      send(OP_EXPAND, 0, 0, '0);
      // load one letter per state whose row holds every state but itself, then expand
      for (int i = 0; i < 16; i++) send(OP_LOAD_SYM, i, i, 16'hFFFF ^ (16'(1) << i));
      send(OP_LOAD_EPS, 15, 0, '0);
      send(OP_START, 0, 0, '0);
      for (int i = 0; i < 4; i++) send(OP_EXPAND, 0, 0, '0);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (50) @(posedge clock);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 27 : phase == 1 ? 83 : 0;
         recv_idle_pct = phase == 0 ? 83 : phase == 1 ? 27 : 0;
         for (int i = 0; i < 16; i++)
            if ($urandom_range(1)) send(OP_LOAD_EPS, i, 0, 16'($urandom) & 16'($urandom));
         run_construction(phase * 30);
         req_valid <= 1'b0;
         @(posedge clock);
         wait (pending_count == 0);
         for (int i = 0; i < 16; i++) send(OP_LOAD_EPS, i, 0, '0);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (1200) @(posedge clock);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

`default_nettype wire

// ===== files.f =====
sv/esc_pkg.sv
sv/esc_ram.sv
sv/esc_closure_unit.sv
sv/epsilon_nfa_subset_construction_unit.sv
test/esc_checker.sv
test/tb_epsilon_nfa_subset_construction_unit.sv
